@@ src/mde_pkg.sv @@
// shared types and protocol constants for the ps2 mouse device engine
`timescale 1ns / 1ps
package mde_pkg;

    // input item from the host side or the motion source
    typedef struct packed {
        logic              command;
        logic [7:0]        host_byte;
        logic [7:0]        prior_host_byte;
        logic [4:0]        button_bits;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic signed [7:0] wheel_h;
        logic signed [7:0] wheel_v;
    } t_in_item;

    // one byte toward the host
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_run;
    } t_out_item;

    // job handed from the front to the back: up to four bytes
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_job;

    // item kinds
    localparam logic CMD_HOST   = 1'b0;
    localparam logic CMD_MOTION = 1'b1;

    // device types
    localparam logic [2:0] KIND_STD   = 3'd0;
    localparam logic [2:0] KIND_WHEEL = 3'd3;
    localparam logic [2:0] KIND_5BTN  = 3'd4;

    // sample rate knock sequences
    localparam logic [23:0] KNOCK_WHEEL = 24'hC86450;
    localparam logic [23:0] KNOCK_5BTN  = 24'hC8C850;

    // host commands
    localparam logic [7:0] HOST_RESET    = 8'hFF;
    localparam logic [7:0] HOST_DEFAULTS = 8'hF6;
    localparam logic [7:0] HOST_DISABLE  = 8'hF5;
    localparam logic [7:0] HOST_ENABLE   = 8'hF4;
    localparam logic [7:0] HOST_RATE     = 8'hF3;
    localparam logic [7:0] HOST_GET_ID   = 8'hF2;
    localparam logic [7:0] HOST_STREAM   = 8'hEA;
    localparam logic [7:0] HOST_STATUS   = 8'hE9;

    // reply bytes
    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] STATUS_RES  = 8'h02;
    localparam logic [7:0] STATUS_RATE = 8'h64;

    // wheel direction codes
    localparam logic [7:0] WHEEL_H_POS = 8'hFE;
    localparam logic [7:0] WHEEL_H_NEG = 8'h02;
    localparam logic [7:0] WHEEL_V_POS = 8'hFF;
    localparam logic [7:0] WHEEL_V_NEG = 8'h01;
    localparam logic [7:0] WHEEL_MIN   = 8'hF8;
    localparam logic [7:0] WHEEL_MAX   = 8'h07;

endpackage

@@ src/mde_front.sv @@
// front end: accepts items, keeps device state, builds the reply byte job
`timescale 1ns / 1ps
module mde_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mde_pkg::t_in_item i_item,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output mde_pkg::t_job    o_job
);
    import mde_pkg::*;

    logic        r_reporting_on, n_reporting_on;
    logic [2:0]  r_device_kind,  n_device_kind;
    logic [23:0] r_rate_history, n_rate_history;

    logic        accept;
    logic        emit;
    logic [23:0] shifted_hist;
    logic [7:0]  b1, ny, wheel, wheel_raw;
    logic        is_wheel;

    assign o_ready = i_job_ready;
    assign accept  = i_valid && i_job_ready;

    assign shifted_hist = {r_rate_history[15:0], i_item.host_byte};
    assign ny           = 8'(-i_item.move_y);
    assign b1 = {2'b00, (i_item.move_y > 8'sd0), i_item.move_x[7], 1'b1,
                 i_item.button_bits[2:0]};
    assign is_wheel = (r_device_kind == KIND_WHEEL) || (r_device_kind == KIND_5BTN);

    always_comb begin
        priority if (i_item.wheel_h == i_item.wheel_v) begin
            priority if (i_item.wheel_v > 8'sd7) begin
                wheel_raw = WHEEL_MIN;
            end else if (i_item.wheel_v < -8'sd7) begin
                wheel_raw = WHEEL_MAX;
            end else begin
                wheel_raw = 8'(-i_item.wheel_v);
            end
        end else if (i_item.wheel_h > 8'sd0) begin
            wheel_raw = WHEEL_H_POS;
        end else if (i_item.wheel_h < 8'sd0) begin
            wheel_raw = WHEEL_H_NEG;
        end else if (i_item.wheel_v > 8'sd0) begin
            wheel_raw = WHEEL_V_POS;
        end else begin
            wheel_raw = WHEEL_V_NEG;
        end
        if (r_device_kind == KIND_5BTN) begin
            wheel = {2'b00, i_item.button_bits[4:3], wheel_raw[3:0]};
        end else begin
            wheel = wheel_raw;
        end
    end

    always_comb begin
        n_reporting_on = r_reporting_on;
        n_device_kind  = r_device_kind;
        n_rate_history = r_rate_history;
        o_job.bytes    = {BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ACK};
        o_job.last_idx = 2'd0;
        emit           = 1'b1;
        if (i_item.command == CMD_MOTION) begin
            emit        = r_reporting_on;
            o_job.bytes = {wheel, ny, i_item.move_x, b1};
            o_job.last_idx = is_wheel ? 2'd3 : 2'd2;
        end else if (i_item.prior_host_byte == HOST_RATE) begin
            n_rate_history = shifted_hist;
            if (r_device_kind == KIND_STD && shifted_hist == KNOCK_WHEEL) begin
                n_device_kind = KIND_WHEEL;
            end else if (r_device_kind == KIND_WHEEL && shifted_hist == KNOCK_5BTN) begin
                n_device_kind = KIND_5BTN;
            end
        end else begin
            unique case (i_item.host_byte)
                HOST_RESET: begin
                    n_reporting_on = 1'b0;
                    n_device_kind  = KIND_STD;
                    o_job.bytes    = {BYTE_ZERO, BYTE_ZERO, BYTE_BAT_OK, BYTE_ACK};
                    o_job.last_idx = 2'd2;
                end
                HOST_DEFAULTS: begin
                    n_reporting_on = 1'b0;
                    n_device_kind  = KIND_STD;
                end
                HOST_DISABLE, HOST_STREAM: n_reporting_on = 1'b0;
                HOST_ENABLE:               n_reporting_on = 1'b1;
                HOST_GET_ID: begin
                    o_job.bytes    = {BYTE_ZERO, BYTE_ZERO, {5'd0, r_device_kind}, BYTE_ACK};
                    o_job.last_idx = 2'd1;
                end
                HOST_STATUS: begin
                    o_job.bytes    = {STATUS_RATE, STATUS_RES, BYTE_ZERO, BYTE_ACK};
                    o_job.last_idx = 2'd3;
                end
                default: ;
            endcase
        end
    end

    assign o_job_valid = i_valid && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reporting_on <= 1'b0;
            r_device_kind  <= KIND_STD;
            r_rate_history <= 24'd0;
        end else if (accept) begin
            r_reporting_on <= n_reporting_on;
            r_device_kind  <= n_device_kind;
            r_rate_history <= n_rate_history;
        end
    end

    // device type only ever holds one of the three legal codes
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_device_kind == KIND_STD || r_device_kind == KIND_WHEEL
        || r_device_kind == KIND_5BTN)
        else $error("illegal device type");

    // a reset command always falls back to the standard mouse
    a_reset_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.command == CMD_HOST && i_item.prior_host_byte != HOST_RATE
        && i_item.host_byte == HOST_RESET |=> r_device_kind == KIND_STD && !r_reporting_on)
        else $error("reset command did not clear state");

endmodule

@@ src/mde_queue.sv @@
// two-entry job queue between front and back
`timescale 1ns / 1ps
module mde_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  mde_pkg::t_job i_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output mde_pkg::t_job o_job
);
    import mde_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_job        = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    // occupancy agrees with the pointer distance
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2 && ((r_count == 2'd1) == (r_wr_ptr != r_rd_ptr)))
        else $error("queue count out of step with pointers");

endmodule

@@ src/mde_back.sv @@
// back end: streams the bytes of each job one per cycle while the receiver is ready
`timescale 1ns / 1ps
module mde_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  mde_pkg::t_job      i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output mde_pkg::t_out_item o_item
);
    import mde_pkg::*;

    logic       r_valid;
    t_job       r_job;
    logic [1:0] r_idx;
    logic       at_last, load;

    assign at_last     = (r_idx == r_job.last_idx);
    assign load        = !r_valid || (i_ready && at_last);
    assign o_job_ready = load;

    assign o_valid            = r_valid;
    assign o_item.tx_byte     = r_job.bytes[r_idx];
    assign o_item.last_of_run = at_last;

    always_ff @(posedge i_clk) begin
        if (load && i_job_valid) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_job_valid;
            r_idx   <= 2'd0;
        end else if (i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // a job in flight is never dropped before its last byte goes out
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !at_last |=> r_valid)
        else $error("job dropped mid-run");

endmodule

@@ src/ps2_mouse_device_engine.sv @@
// top level of the ps2 mouse device engine
`timescale 1ns / 1ps
// Device side of a PS/2 mouse with wheel and five-button extensions.
// Input channel (i_valid/o_ready, i_item): either a host command byte with
// the byte that preceded it, or a motion report (buttons, dx, dy, wheels).
// Output channel (o_valid/i_ready, o_item): bytes queued to the host, one
// per item handshake, with last_of_run on the final byte of each input.
// Commands give an ACK plus replies for reset, get ID and status; motion
// gives a 3-byte packet, or 4 bytes once the rate knock selects a wheel
// type. Motion while reporting is off yields no output at all.
// An accepted item's reply bytes pass as a job through the job queue
// and then into the output register.
// Throughput: the output register sends one byte per cycle while i_ready
// is high, and a job holds 1 to 4 bytes; the front accepts one item a cycle
// while the two-entry queue has room.
// Reset clears reporting, device type and rate history and empties the
// queue. When the receiver stalls the current byte holds, the queue fills
// and then o_ready drops until bytes drain.
module ps2_mouse_device_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mde_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output mde_pkg::t_out_item o_item
);
    import mde_pkg::*;

    // front to queue
    logic f_valid, f_ready;
    t_job f_job;
    // queue to back
    logic q_valid, q_ready;
    t_job q_job;

    // classify the item, update device state, build the reply bytes
    mde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    // decouples command handling from the byte-serial output
    mde_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_job        (f_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_job        (q_job)
    );

    // one byte per cycle to the host side while it is ready
    mde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

@@ sim/tb.sv @@
// testbench for the ps2 mouse device engine: directed and random items checked byte by byte
`timescale 1ns / 1ps
module tb;
    import mde_pkg::*;

    localparam int LIMIT_CYCLES   = 500000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS   = 480;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    // predicted device state
    logic        streaming  = 1'b0;
    logic [2:0]  mouse_kind = KIND_STD;
    logic [23:0] rate_shift = '0;

    // bytes the host should see, oldest first
    t_out_item pending_host_bytes[$];

    int  mismatch_cnt = 0;
    int  cycle_cnt    = 0;
    int  items_sent   = 0;
    bit  tx_idle_on   = 1'b1;
    bit  rx_idle_on   = 1'b1;
    bit  hold_req     = 1'b0;

    ps2_mouse_device_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_in_item random_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return t_in_item'(r[$bits(t_in_item)-1:0]);
    endfunction

    function automatic logic [7:0] non_rate_prior();
        logic [7:0] p;
        p = 8'($urandom);
        if (p == HOST_RATE)
            p = p ^ 8'h01;
        return p;
    endfunction

    function automatic t_in_item host_cmd_item(input logic [7:0] b, input logic [7:0] prior);
        t_in_item it;
        it                 = random_item();
        it.command         = CMD_HOST;
        it.host_byte       = b;
        it.prior_host_byte = prior;
        return it;
    endfunction

    function automatic t_in_item motion_item(input logic [4:0] btn,
                                             input logic [7:0] x, y, h, v);
        t_in_item it;
        it             = random_item();
        it.command     = CMD_MOTION;
        it.button_bits = btn;
        it.move_x      = x;
        it.move_y      = y;
        it.wheel_h     = h;
        it.wheel_v     = v;
        return it;
    endfunction

    // works out the host bytes one accepted item causes and updates device state
    task automatic predict_host_bytes(input t_in_item it);
        logic [7:0]        reply [4];
        int                cnt;
        int                k;
        logic [8:0]        neg_y;
        int                h;
        int                v;
        int                z;
        logic [7:0]        w;
        t_out_item         o;
        cnt = 0;
        if (it.command == CMD_HOST) begin
            if (it.prior_host_byte == HOST_RATE) begin
                // byte is a sample rate, feeds the knock detector
                rate_shift = {rate_shift[15:0], it.host_byte};
                if (mouse_kind == KIND_STD && rate_shift == KNOCK_WHEEL)
                    mouse_kind = KIND_WHEEL;
                else if (mouse_kind == KIND_WHEEL && rate_shift == KNOCK_5BTN)
                    mouse_kind = KIND_5BTN;
                reply[cnt] = BYTE_ACK;
                cnt++;
            end else begin
                reply[cnt] = BYTE_ACK;
                cnt++;
                case (it.host_byte)
                    HOST_RESET: begin
                        streaming  = 1'b0;
                        mouse_kind = KIND_STD;
                        reply[cnt] = BYTE_BAT_OK;
                        cnt++;
                        reply[cnt] = BYTE_ZERO;
                        cnt++;
                    end
                    HOST_DEFAULTS: begin
                        streaming  = 1'b0;
                        mouse_kind = KIND_STD;
                    end
                    HOST_DISABLE, HOST_STREAM: streaming = 1'b0;
                    HOST_ENABLE: streaming = 1'b1;
                    HOST_GET_ID: begin
                        reply[cnt] = {5'b0, mouse_kind};
                        cnt++;
                    end
                    HOST_STATUS: begin
                        reply[cnt] = BYTE_ZERO;
                        cnt++;
                        reply[cnt] = STATUS_RES;
                        cnt++;
                        reply[cnt] = STATUS_RATE;
                        cnt++;
                    end
                    default: ;
                endcase
            end
        end else if (streaming) begin
            // y is negated at nine bits so -128 becomes +128 with sign clear
            neg_y      = -{it.move_y[7], it.move_y};
            reply[cnt] = {2'b00, neg_y[8], it.move_x[7], 1'b1, it.button_bits[2:0]};
            cnt++;
            reply[cnt] = it.move_x;
            cnt++;
            reply[cnt] = neg_y[7:0];
            cnt++;
            if (mouse_kind == KIND_WHEEL || mouse_kind == KIND_5BTN) begin
                h = $signed(it.wheel_h);
                v = $signed(it.wheel_v);
                if (h == v) begin
                    z = -v;
                    if (z < $signed(WHEEL_MIN))
                        w = WHEEL_MIN;
                    else if (z > $signed(WHEEL_MAX))
                        w = WHEEL_MAX;
                    else
                        w = 8'(z);
                end else if (h > 0) begin
                    w = WHEEL_H_POS;
                end else if (h < 0) begin
                    w = WHEEL_H_NEG;
                end else if (v > 0) begin
                    w = WHEEL_V_POS;
                end else begin
                    w = WHEEL_V_NEG;
                end
                if (mouse_kind == KIND_5BTN)
                    w = {2'b00, it.button_bits[4:3], w[3:0]};
                reply[cnt] = w;
                cnt++;
            end
        end
        for (k = 0; k < cnt; k++) begin
            o.tx_byte     = reply[k];
            o.last_of_run = (k == cnt - 1);
            pending_host_bytes.push_back(o);
        end
    endtask

    // offers one item, optional gap first; valid stays high afterwards
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 1) == 0)
            gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        predict_host_bytes(it);
        items_sent++;
    endtask

    // sender pauses until every predicted byte has arrived
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_host_bytes.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial begin : rx_side
        int k;
        int len;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                for (k = 1; k < RX_HOLD_CYCLES; k++) @(negedge i_clk);
            end else if (!rx_idle_on || $urandom_range(0, 2) != 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                len = gap_len();
                for (k = 1; k < len; k++) @(negedge i_clk);
            end
        end
    end

    // compares each byte the host takes with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_host_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, got %02h last %b",
                         $time, o_item.tx_byte, o_item.last_of_run);
                mismatch_cnt++;
            end else begin
                want = pending_host_bytes.pop_front();
                if (o_item.tx_byte !== want.tx_byte) begin
                    $display("%0t: tx_byte expected %02h got %02h",
                             $time, want.tx_byte, o_item.tx_byte);
                    mismatch_cnt++;
                end
                if (o_item.last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run expected %b got %b",
                             $time, want.last_of_run, o_item.last_of_run);
                    mismatch_cnt++;
                end
            end
        end
    end

    // reset, id, status, mode commands, motion while reporting is off
    task automatic test_host_commands();
        send_item(host_cmd_item(HOST_RESET, 8'h00));
        send_item(host_cmd_item(HOST_GET_ID, HOST_RESET));
        send_item(host_cmd_item(HOST_STATUS, 8'h00));
        send_item(motion_item(5'h1F, 8'h80, 8'h80, 8'h80, 8'h80));
        send_item(host_cmd_item(HOST_ENABLE, 8'hFF));
        send_item(host_cmd_item(HOST_DISABLE, 8'h00));
        send_item(host_cmd_item(HOST_STREAM, 8'h00));
        send_item(host_cmd_item(HOST_DEFAULTS, 8'h00));
        send_item(host_cmd_item(8'h00, 8'hFF));
        // a reset code after the rate command is only a rate
        send_item(host_cmd_item(HOST_RESET, HOST_RATE));
    endtask

    // rates 200,100,80 select the wheel type
    task automatic test_wheel_upgrade();
        send_item(host_cmd_item(KNOCK_WHEEL[23:16], HOST_RATE));
        send_item(host_cmd_item(KNOCK_WHEEL[15:8], HOST_RATE));
        send_item(host_cmd_item(KNOCK_WHEEL[7:0], HOST_RATE));
        send_item(host_cmd_item(HOST_GET_ID, 8'h00));
        send_item(host_cmd_item(HOST_ENABLE, 8'h00));
        send_item(motion_item(5'h1F, 8'h80, 8'h80, 8'h80, 8'h80));
        send_item(motion_item(5'h00, 8'h00, 8'h00, 8'h01, 8'h00));
    endtask

    // rates 200,200,80 then select five buttons; wheel code cases
    task automatic test_five_button();
        send_item(host_cmd_item(KNOCK_5BTN[23:16], HOST_RATE));
        send_item(host_cmd_item(KNOCK_5BTN[15:8], HOST_RATE));
        send_item(host_cmd_item(KNOCK_5BTN[7:0], HOST_RATE));
        send_item(host_cmd_item(HOST_GET_ID, 8'h00));
        send_item(motion_item(5'h18, 8'h7F, 8'h7F, 8'h7F, 8'h7F));
        send_item(motion_item(5'h1F, 8'h01, 8'hFF, 8'hFF, 8'h05));
        send_item(motion_item(5'h08, 8'hFF, 8'h01, 8'h00, 8'h03));
        send_item(motion_item(5'h10, 8'h40, 8'hC0, 8'h00, 8'hFD));
        send_item(motion_item(5'h07, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // receiver holds off long while the sender keeps offering packets
    task automatic test_rx_backpressure();
        int k;
        wait_drained();
        tx_idle_on = 1'b0;
        send_item(host_cmd_item(HOST_ENABLE, 8'h00));
        hold_req = 1'b1;
        for (k = 0; k < 24; k++)
            send_item(motion_item(5'($urandom), 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom)));
        wait_drained();
        tx_idle_on = 1'b1;
    endtask

    // mostly knock sequences, enables and motion, plus commands and noise
    task automatic test_random_traffic(input int n_items);
        int          target;
        int          phase;
        int          pick;
        int          j;
        logic [23:0] knock;
        logic [7:0]  rate;
        logic [7:0]  named_cmds [6];
        t_in_item    it;
        named_cmds = '{HOST_RESET, HOST_DEFAULTS, HOST_DISABLE,
                       HOST_STREAM, HOST_GET_ID, HOST_STATUS};
        target = items_sent + n_items;
        while (items_sent < target) begin
            // idling phases: both, sender only, receiver only, none
            phase      = ((target - items_sent) / 60) % 4;
            tx_idle_on = (phase == 0 || phase == 1);
            rx_idle_on = (phase == 0 || phase == 2);
            pick       = $urandom_range(0, 99);
            if (pick < 45) begin
                it         = random_item();
                it.command = CMD_MOTION;
                case ($urandom_range(0, 3))
                    0: it.wheel_h = it.wheel_v;
                    1: begin
                        it.wheel_h = 8'($urandom_range(0, 2)) - 8'd1;
                        it.wheel_v = 8'($urandom_range(0, 2)) - 8'd1;
                    end
                    default: ;
                endcase
                send_item(it);
            end else if (pick < 55) begin
                knock = $urandom_range(0, 1) ? KNOCK_5BTN : KNOCK_WHEEL;
                for (j = 0; j < 3; j++) begin
                    rate = knock[23 - 8 * j -: 8];
                    if ($urandom_range(0, 7) == 0)
                        rate = 8'($urandom);
                    send_item(host_cmd_item(HOST_RATE, non_rate_prior()));
                    send_item(host_cmd_item(rate, HOST_RATE));
                end
            end else if (pick < 62) begin
                send_item(host_cmd_item(HOST_ENABLE, non_rate_prior()));
            end else if (pick < 72) begin
                send_item(host_cmd_item(named_cmds[$urandom_range(0, 5)], non_rate_prior()));
            end else if (pick < 80) begin
                send_item(host_cmd_item(8'($urandom), HOST_RATE));
            end else begin
                send_item(random_item());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin : main_seq
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_host_commands();
        test_wheel_upgrade();
        test_five_button();
        test_rx_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : watchdog
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
